// File: hdl/plw_pkg.sv
`timescale 1ns / 1ps

package plw_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int PIXEL_BITS     = 16;
    localparam int SIZE_BITS      = 16;
    localparam int TOTAL_BITS     = 2 * SIZE_BITS;
    localparam int BYTE_BITS      = 8;

    localparam logic [SIZE_BITS-1:0] WIDTH_RST  = 16'd320;
    localparam logic [SIZE_BITS-1:0] HEIGHT_RST = 16'd240;

    localparam logic [BYTE_BITS-1:0] CMD_COLUMN = 8'h2A;
    localparam logic [BYTE_BITS-1:0] CMD_ROW    = 8'h2B;
    localparam logic [BYTE_BITS-1:0] CMD_WRITE  = 8'h2C;

    typedef enum logic [1:0] {
        CFG_X0     = 2'd0,
        CFG_Y0     = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        STEP_COL_CMD = 4'd0,
        STEP_XS_HI   = 4'd1,
        STEP_XS_LO   = 4'd2,
        STEP_XE_HI   = 4'd3,
        STEP_XE_LO   = 4'd4,
        STEP_ROW_CMD = 4'd5,
        STEP_YS_HI   = 4'd6,
        STEP_YS_LO   = 4'd7,
        STEP_YE_HI   = 4'd8,
        STEP_YE_LO   = 4'd9,
        STEP_WR_CMD  = 4'd10,
        STEP_PIX_HI  = 4'd11,
        STEP_PIX_LO  = 4'd12
    } step_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic                  first;
        logic                  cs_rel;
    } item_t;

endpackage

// File: hdl/plw_cfg.sv
`timescale 1ns / 1ps

module plw_cfg #(
    parameter int COORD_BITS = plw_pkg::COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [plw_pkg::SIZE_BITS-1:0]  cfg_data,
    output logic                           settle,
    output logic [COORD_BITS-1:0]          x_start,
    output logic [COORD_BITS-1:0]          x_end,
    output logic [COORD_BITS-1:0]          y_start,
    output logic [COORD_BITS-1:0]          y_end,
    output logic [plw_pkg::TOTAL_BITS-1:0] total
);

    logic [COORD_BITS-1:0]          x0_reg;
    logic [COORD_BITS-1:0]          y0_reg;
    logic [plw_pkg::SIZE_BITS-1:0]  width_reg;
    logic [plw_pkg::SIZE_BITS-1:0]  height_reg;
    logic [COORD_BITS-1:0]          x_end_reg;
    logic [COORD_BITS-1:0]          y_end_reg;
    logic [plw_pkg::TOTAL_BITS-1:0] total_reg;
    logic                           settle_reg;
    logic                           wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x0_reg     <= '0;
            y0_reg     <= '0;
            width_reg  <= plw_pkg::WIDTH_RST;
            height_reg <= plw_pkg::HEIGHT_RST;
            x_end_reg  <= COORD_BITS'(plw_pkg::WIDTH_RST - 16'd1);
            y_end_reg  <= COORD_BITS'(plw_pkg::HEIGHT_RST - 16'd1);
            total_reg  <= plw_pkg::TOTAL_BITS'(plw_pkg::WIDTH_RST)
                          * plw_pkg::TOTAL_BITS'(plw_pkg::HEIGHT_RST);
            settle_reg <= 1'b0;
        end
        else
        begin
            settle_reg <= wr;
            x_end_reg  <= COORD_BITS'(16'(x0_reg) + width_reg - 16'd1);
            y_end_reg  <= COORD_BITS'(16'(y0_reg) + height_reg - 16'd1);
            total_reg  <= plw_pkg::TOTAL_BITS'(width_reg)
                          * plw_pkg::TOTAL_BITS'(height_reg);
            if (wr)
            begin
                unique case (plw_pkg::cfg_idx_t'(cfg_index))
                    plw_pkg::CFG_X0:     x0_reg     <= COORD_BITS'(cfg_data);
                    plw_pkg::CFG_Y0:     y0_reg     <= COORD_BITS'(cfg_data);
                    plw_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                    plw_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                endcase
            end
        end
    end

    assign settle  = settle_reg;
    assign x_start = x0_reg;
    assign y_start = y0_reg;
    assign x_end   = x_end_reg;
    assign y_end   = y_end_reg;
    assign total   = total_reg;

endmodule

// File: hdl/plw_front.sv
`timescale 1ns / 1ps

module plw_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [plw_pkg::PIXEL_BITS-1:0] pixel,
    input  logic                           settle,
    input  logic [plw_pkg::TOTAL_BITS-1:0] total,
    input  logic                           q_full,
    output logic                           push,
    output plw_pkg::item_t                 push_item
);

    logic [plw_pkg::TOTAL_BITS-1:0] count_reg;
    logic [plw_pkg::TOTAL_BITS-1:0] count_next;
    logic [plw_pkg::TOTAL_BITS-1:0] count_inc;
    logic                           frame_end;

    assign in_stall  = q_full || settle;
    assign push      = in_valid && !in_stall;
    assign count_inc = count_reg + plw_pkg::TOTAL_BITS'(1);
    assign frame_end = count_inc >= total;

    always_comb
    begin
        push_item.pixel  = pixel;
        push_item.first  = (count_reg == '0);
        push_item.cs_rel = frame_end;
        count_next       = count_reg;
        if (push)
        begin
            count_next = frame_end ? '0 : count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// File: hdl/plw_fifo.sv
`timescale 1ns / 1ps

module plw_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  plw_pkg::item_t push_item,
    input  logic           pop,
    output plw_pkg::item_t head,
    output logic           empty,
    output logic           full
);

    plw_pkg::item_t mem [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'd2))
        else $error("Queue written while full.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != 2'd0))
        else $error("Queue read while empty.");

endmodule

// File: hdl/plw_back.sv
`timescale 1ns / 1ps

module plw_back #(
    parameter int COORD_BITS = plw_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  plw_pkg::item_t                head,
    input  logic                          q_empty,
    output logic                          pop,
    input  logic [COORD_BITS-1:0]         x_start,
    input  logic [COORD_BITS-1:0]         x_end,
    input  logic [COORD_BITS-1:0]         y_start,
    input  logic [COORD_BITS-1:0]         y_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [plw_pkg::BYTE_BITS-1:0] bus_byte,
    output logic                          is_command,
    output logic                          cs_release,
    output logic                          last
);

    plw_pkg::step_t                step_reg;
    plw_pkg::step_t                step_next;
    plw_pkg::step_t                cur_step;
    logic                          advance;
    logic                          fire;
    logic [15:0]                   xs_w;
    logic [15:0]                   xe_w;
    logic [15:0]                   ys_w;
    logic [15:0]                   ye_w;
    logic [plw_pkg::BYTE_BITS-1:0] byte_sel;
    logic                          cmd_sel;
    logic                          out_valid_reg;
    logic [plw_pkg::BYTE_BITS-1:0] byte_reg;
    logic                          cmd_reg;
    logic                          rel_reg;
    logic                          last_reg;

    assign xs_w = 16'(x_start);
    assign xe_w = 16'(x_end);
    assign ys_w = 16'(y_start);
    assign ye_w = 16'(y_end);

    assign advance = !out_valid_reg || !out_stall;
    assign fire    = advance && !q_empty;

    always_comb
    begin
        cur_step = step_reg;
        if (step_reg == plw_pkg::STEP_COL_CMD && !head.first)
        begin
            cur_step = plw_pkg::STEP_PIX_HI;
        end
        cmd_sel = 1'b0;
        unique case (cur_step)
            plw_pkg::STEP_COL_CMD:
            begin
                byte_sel = plw_pkg::CMD_COLUMN;
                cmd_sel  = 1'b1;
            end
            plw_pkg::STEP_XS_HI:   byte_sel = xs_w[15:8];
            plw_pkg::STEP_XS_LO:   byte_sel = xs_w[7:0];
            plw_pkg::STEP_XE_HI:   byte_sel = xe_w[15:8];
            plw_pkg::STEP_XE_LO:   byte_sel = xe_w[7:0];
            plw_pkg::STEP_ROW_CMD:
            begin
                byte_sel = plw_pkg::CMD_ROW;
                cmd_sel  = 1'b1;
            end
            plw_pkg::STEP_YS_HI:   byte_sel = ys_w[15:8];
            plw_pkg::STEP_YS_LO:   byte_sel = ys_w[7:0];
            plw_pkg::STEP_YE_HI:   byte_sel = ye_w[15:8];
            plw_pkg::STEP_YE_LO:   byte_sel = ye_w[7:0];
            plw_pkg::STEP_WR_CMD:
            begin
                byte_sel = plw_pkg::CMD_WRITE;
                cmd_sel  = 1'b1;
            end
            plw_pkg::STEP_PIX_HI:  byte_sel = head.pixel[15:8];
            plw_pkg::STEP_PIX_LO:  byte_sel = head.pixel[7:0];
            default:               byte_sel = '0;
        endcase
        pop       = fire && (cur_step == plw_pkg::STEP_PIX_LO);
        step_next = step_reg;
        if (fire)
        begin
            step_next = pop ? plw_pkg::STEP_COL_CMD
                            : plw_pkg::step_t'(cur_step + 4'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= plw_pkg::STEP_COL_CMD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (advance)
            begin
                out_valid_reg <= !q_empty;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            byte_reg <= byte_sel;
            cmd_reg  <= cmd_sel;
            rel_reg  <= pop && head.cs_rel;
            last_reg <= pop;
        end
    end

    assign out_valid  = out_valid_reg;
    assign bus_byte   = byte_reg;
    assign is_command = cmd_reg;
    assign cs_release = rel_reg;
    assign last       = last_reg;

    a_release_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rel_reg) |-> last_reg)
        else $error("Chip select released on a beat that does not end a pixel.");

    a_command_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && cmd_reg) |-> !last_reg)
        else $error("Command beat marked as last of a pixel.");

endmodule

// File: hdl/parallel_lcd_window_pixel_writer.sv
`timescale 1ns / 1ps

// Channel   Signals                                    Direction  Handshake
// input     in_valid, in_stall, pixel                  in         valid / stall
// output    out_valid, out_stall, bus_byte,            out        valid / stall
//           is_command, cs_release, last
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  in         valid / ready
//
// One bus write leaves per cycle while out_stall is low and a pixel is queued, so a pixel
// takes two bus writes in steady state and the first pixel of a frame takes thirteen;
// the byte sequencer in the back end sets this sequence.
// A two-entry queue separates the pixel classifier from the sequencer, so input
// keeps flowing for a while when the output is stalled.
// Reset is asynchronous and active low; there is no clearing pass.
// The input is stalled in the cycle after each configuration write.

module parallel_lcd_window_pixel_writer #(
    parameter int COORD_BITS = plw_pkg::COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [plw_pkg::PIXEL_BITS-1:0] pixel,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [plw_pkg::BYTE_BITS-1:0]  bus_byte,
    output logic                           is_command,
    output logic                           cs_release,
    output logic                           last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [plw_pkg::SIZE_BITS-1:0]  cfg_data
);

    logic                           settle;
    logic [COORD_BITS-1:0]          x_start;
    logic [COORD_BITS-1:0]          x_end;
    logic [COORD_BITS-1:0]          y_start;
    logic [COORD_BITS-1:0]          y_end;
    logic [plw_pkg::TOTAL_BITS-1:0] total;
    logic                           push;
    plw_pkg::item_t                 push_item;
    logic                           pop;
    plw_pkg::item_t                 head;
    logic                           q_empty;
    logic                           q_full;

    plw_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .settle    (settle),
        .x_start   (x_start),
        .x_end     (x_end),
        .y_start   (y_start),
        .y_end     (y_end),
        .total     (total)
    );

    plw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel     (pixel),
        .settle    (settle),
        .total     (total),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    plw_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    plw_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_empty    (q_empty),
        .pop        (pop),
        .x_start    (x_start),
        .x_end      (x_end),
        .y_start    (y_start),
        .y_end      (y_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .bus_byte   (bus_byte),
        .is_command (is_command),
        .cs_release (cs_release),
        .last       (last)
    );

endmodule

// File: tb/tb_parallel_lcd_window_pixel_writer.sv
`timescale 1ns / 1ps

module tb_parallel_lcd_window_pixel_writer;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int LONG_HOLD     = 150;
    localparam int RANDOM_ITEMS  = 150;
    localparam int STEADY_ITEMS  = 25;
    localparam int PRESSURE_ITEMS = 24;
    localparam logic [plw_pkg::SIZE_BITS-1:0] COORD_MASK =
        plw_pkg::SIZE_BITS'((1 << plw_pkg::COORD_BITS_DEF) - 1);

    typedef struct packed {
        logic [plw_pkg::BYTE_BITS-1:0] bus_byte;
        logic                          is_command;
        logic                          cs_release;
        logic                          last;
    } bus_write_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [plw_pkg::PIXEL_BITS-1:0] pixel;
    logic                           out_valid;
    logic                           out_stall;
    logic [plw_pkg::BYTE_BITS-1:0]  bus_byte;
    logic                           is_command;
    logic                           cs_release;
    logic                           last;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [1:0]                     cfg_index;
    logic [plw_pkg::SIZE_BITS-1:0]  cfg_data;

    logic [plw_pkg::SIZE_BITS-1:0]  win_col0   = '0;
    logic [plw_pkg::SIZE_BITS-1:0]  win_row0   = '0;
    logic [plw_pkg::SIZE_BITS-1:0]  win_cols   = plw_pkg::WIDTH_RST;
    logic [plw_pkg::SIZE_BITS-1:0]  win_rows   = plw_pkg::HEIGHT_RST;
    logic [plw_pkg::TOTAL_BITS-1:0] frame_pixels = '0;

    bus_write_t expected_writes[$];
    bit         failed = 1'b0;
    bit         idle_en = 1'b1;
    bit         hold_req = 1'b0;
    int         cycle_count = 0;

    parallel_lcd_window_pixel_writer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel      (pixel),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .bus_byte   (bus_byte),
        .is_command (is_command),
        .cs_release (cs_release),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void push_write(input logic [plw_pkg::BYTE_BITS-1:0] value,
                                       input logic cmd);
        bus_write_t w;
        w.bus_byte   = value;
        w.is_command = cmd;
        w.cs_release = 1'b0;
        w.last       = 1'b0;
        expected_writes.push_back(w);
    endfunction

    function automatic void push_coord_pair(input logic [plw_pkg::SIZE_BITS-1:0] start,
                                            input logic [plw_pkg::SIZE_BITS-1:0] size);
        logic [plw_pkg::SIZE_BITS-1:0] s;
        logic [plw_pkg::SIZE_BITS-1:0] e;
        s = start & COORD_MASK;
        e = (start + size - plw_pkg::SIZE_BITS'(1)) & COORD_MASK;
        push_write(s[15:8], 1'b0);
        push_write(s[7:0], 1'b0);
        push_write(e[15:8], 1'b0);
        push_write(e[7:0], 1'b0);
    endfunction

    function automatic void predict_bus_writes(input logic [plw_pkg::PIXEL_BITS-1:0] px);
        logic [plw_pkg::TOTAL_BITS-1:0] area;
        bus_write_t                     tail;
        area = plw_pkg::TOTAL_BITS'(win_cols) * plw_pkg::TOTAL_BITS'(win_rows);
        if (frame_pixels == '0)
        begin
            push_write(plw_pkg::CMD_COLUMN, 1'b1);
            push_coord_pair(win_col0, win_cols);
            push_write(plw_pkg::CMD_ROW, 1'b1);
            push_coord_pair(win_row0, win_rows);
            push_write(plw_pkg::CMD_WRITE, 1'b1);
        end
        push_write(px[15:8], 1'b0);
        push_write(px[7:0], 1'b0);
        tail = expected_writes.pop_back();
        tail.last = 1'b1;
        frame_pixels = frame_pixels + plw_pkg::TOTAL_BITS'(1);
        if (frame_pixels >= area)
        begin
            tail.cs_release = 1'b1;
            frame_pixels = '0;
        end
        expected_writes.push_back(tail);
    endfunction

    function automatic void apply_window_reg(input plw_pkg::cfg_idx_t idx,
                                             input logic [plw_pkg::SIZE_BITS-1:0] value);
        case (idx)
            plw_pkg::CFG_X0:     win_col0 = value;
            plw_pkg::CFG_Y0:     win_row0 = value;
            plw_pkg::CFG_WIDTH:  win_cols = value;
            plw_pkg::CFG_HEIGHT: win_rows = value;
            default:             ;
        endcase
    endfunction

    always @(posedge clk)
    begin : monitor
        bus_write_t got;
        bus_write_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                apply_window_reg(plw_pkg::cfg_idx_t'(cfg_index), cfg_data);
            end
            if (in_valid && !in_stall)
            begin
                predict_bus_writes(pixel);
            end
            if (out_valid && !out_stall)
            begin
                got = {bus_byte, is_command, cs_release, last};
                if (expected_writes.size() == 0)
                begin
                    $error("unexpected bus write beat: bus_byte %h", bus_byte);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_writes.pop_front();
                    if (got.bus_byte !== want.bus_byte)
                    begin
                        $error("bus_byte: expected %h, actual %h", want.bus_byte, got.bus_byte);
                        failed = 1'b1;
                    end
                    if (got.is_command !== want.is_command)
                    begin
                        $error("is_command: expected %b, actual %b",
                               want.is_command, got.is_command);
                        failed = 1'b1;
                    end
                    if (got.cs_release !== want.cs_release)
                    begin
                        $error("cs_release: expected %b, actual %b",
                               want.cs_release, got.cs_release);
                        failed = 1'b1;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last: expected %b, actual %b", want.last, got.last);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    initial
    begin : receiver
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 4);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_pixel(input logic [plw_pkg::PIXEL_BITS-1:0] px);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= px;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_writes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_beat(input plw_pkg::cfg_idx_t idx,
                            input logic [plw_pkg::SIZE_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic set_window(input logic [plw_pkg::SIZE_BITS-1:0] x0,
                              input logic [plw_pkg::SIZE_BITS-1:0] y0,
                              input logic [plw_pkg::SIZE_BITS-1:0] w,
                              input logic [plw_pkg::SIZE_BITS-1:0] h);
        wait_idle();
        cfg_beat(plw_pkg::CFG_X0, x0);
        cfg_beat(plw_pkg::CFG_Y0, y0);
        cfg_beat(plw_pkg::CFG_WIDTH, w);
        cfg_beat(plw_pkg::CFG_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random_phase(output int sent);
        logic [plw_pkg::SIZE_BITS-1:0]  w;
        logic [plw_pkg::SIZE_BITS-1:0]  h;
        logic [plw_pkg::TOTAL_BITS-1:0] area;
        int                             n;
        case ($urandom_range(0, 7))
            0:
            begin
                w = '0;
                h = plw_pkg::SIZE_BITS'($urandom_range(1, 3));
            end
            1:
            begin
                w = plw_pkg::SIZE_BITS'($urandom);
                h = plw_pkg::SIZE_BITS'($urandom);
            end
            2:
            begin
                w = plw_pkg::SIZE_BITS'($urandom_range(1, 3));
                h = '0;
            end
            default:
            begin
                w = plw_pkg::SIZE_BITS'($urandom_range(1, 5));
                h = plw_pkg::SIZE_BITS'($urandom_range(1, 4));
            end
        endcase
        set_window(plw_pkg::SIZE_BITS'($urandom), plw_pkg::SIZE_BITS'($urandom), w, h);
        area = plw_pkg::TOTAL_BITS'(w) * plw_pkg::TOTAL_BITS'(h);
        if (area != 0 && area <= 20)
        begin
            n = int'(area) * int'($urandom_range(1, 2)) + int'($urandom_range(0, 2));
        end
        else
        begin
            n = int'($urandom_range(1, 6));
        end
        repeat (n) send_pixel(plw_pkg::PIXEL_BITS'($urandom));
        sent = n;
    endtask

    task automatic test_default_window();
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'h00FF);
    endtask

    // The frame already holds three pixels, so the first pixel after the
    // shrink ends it at once.
    task automatic test_window_shrink_mid_frame();
        set_window(16'h0000, 16'h0000, 16'd2, 16'd1);
        send_pixel(16'hFF00);
        send_pixel(16'h8001);
        send_pixel(16'h7FFE);
    endtask

    task automatic test_extreme_window();
        set_window(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'hAAAA);
        send_pixel(16'h5555);
    endtask

    task automatic test_zero_size_window();
        set_window(16'h0010, 16'h0020, 16'd0, 16'd5);
        send_pixel(16'h1234);
        send_pixel(16'hFEDC);
        send_pixel(16'h0F0F);
        set_window(16'h0100, 16'h0200, 16'd3, 16'd0);
        send_pixel(16'hF0F0);
        send_pixel(16'h0001);
    endtask

    task automatic test_one_pixel_window();
        set_window(16'h1234, 16'hABCD, 16'd1, 16'd1);
        send_pixel(16'h8000);
        send_pixel(16'h0080);
        send_pixel(16'hC3A5);
    endtask

    task automatic test_random_frames();
        int total;
        int n;
        total = 0;
        while (total < RANDOM_ITEMS)
        begin
            run_random_phase(n);
            total += n;
        end
    endtask

    task automatic test_output_backpressure();
        set_window(plw_pkg::SIZE_BITS'($urandom), plw_pkg::SIZE_BITS'($urandom),
                   16'd4, 16'd3);
        hold_req = 1'b1;
        repeat (PRESSURE_ITEMS) send_pixel(plw_pkg::PIXEL_BITS'($urandom));
    endtask

    task automatic test_steady_stream();
        int total;
        int n;
        wait_idle();
        idle_en = 1'b0;
        total = 0;
        while (total < STEADY_ITEMS)
        begin
            run_random_phase(n);
            total += n;
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        pixel     = '0;
        cfg_valid = 1'b0;
        cfg_index = plw_pkg::CFG_X0;
        cfg_data  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_window();
        test_window_shrink_mid_frame();
        test_extreme_window();
        test_zero_size_window();
        test_one_pixel_window();
        test_random_frames();
        test_output_backpressure();
        test_steady_stream();
        wait_idle();
        if (failed)
        begin
            $display("Mismatches found");
        end
        else
        begin
            $display("No mismatches found");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/plw_pkg.sv
hdl/plw_cfg.sv
hdl/plw_front.sv
hdl/plw_fifo.sv
hdl/plw_back.sv
hdl/parallel_lcd_window_pixel_writer.sv
tb/tb_parallel_lcd_window_pixel_writer.sv
